// ----- rtl/ssc_pkg.sv -----
`default_nettype none
package ssc_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_HALF  = 3;
    localparam int MAX_ROWS  = 4096;
    localparam int RING_ROWS = 2 * MAX_HALF;
    localparam int WIN_LEN   = 2 * MAX_HALF + 1;

    localparam int COL_W   = $clog2(MAX_COLS);          // column index
    localparam int CNT_W   = COL_W + 1;                 // column count / width reg
    localparam int ROW_W   = 13;                        // row count / height reg
    localparam int SLOT_W  = $clog2(RING_ROWS);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int DEPTH   = RING_ROWS * MAX_COLS;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int CSUM_W  = 28;                        // column sum
    localparam int HACC_W  = 48;                        // row sum, Q28
    localparam int TAP_W   = 3;                         // tap counter 0..6
    localparam int HALF_W  = 2;
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VADDR,
        ST_VMAC,
        ST_SHIFT,
        ST_HMAC,
        ST_HOUT,
        ST_WRITE
    } ssc_state_t;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_HALF   = 3'd2,
        REG_COEF0  = 3'd3,
        REG_COEF1  = 3'd4,
        REG_COEF2  = 3'd5,
        REG_COEF3  = 3'd6,
        REG_NONE   = 3'd7
    } ssc_reg_t;

endpackage
`default_nettype wire

// ----- rtl/ssc_cell.sv -----
`default_nettype none
// one column-sum tap of the horizontal window
module ssc_cell (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               shift_en,
    input  wire logic signed [ssc_pkg::CSUM_W-1:0]  d_in,
    output logic signed [ssc_pkg::CSUM_W-1:0]       q_out
);
    logic signed [ssc_pkg::CSUM_W-1:0] tap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else if (shift_en) begin
            tap_reg <= d_in;
        end
    end

    assign q_out = tap_reg;
endmodule
`default_nettype wire

// ----- rtl/ssc_line_store.sv -----
`default_nettype none
// ring of raw rows, one write and one registered read per cycle
module ssc_line_store (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [ssc_pkg::ADDR_W-1:0]    wr_addr,
    input  wire logic [ssc_pkg::PIX_W-1:0]     wr_data,
    input  wire logic                          rd_en,
    input  wire logic [ssc_pkg::ADDR_W-1:0]    rd_addr,
    output logic [ssc_pkg::PIX_W-1:0]          rd_data
);
    logic [ssc_pkg::PIX_W-1:0] mem [0:ssc_pkg::DEPTH-1];
    logic [ssc_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ----- rtl/symmetric_separable_convolution_top.sv -----
`default_nettype none
// Separable symmetric 2-D FIR over a raster-order 8-bit image with replicate
// borders. One request at a time: a request walks its vertical taps, shifts
// the column-sum chain, then produces its results (h = half_width, up to four
// results at a row end), each of which may wait for the receiver. A request
// in the first h rows only fills the line store. One multiply-accumulate
// at a time does the work, walking the vertical taps through the line
// store's one read port and then the horizontal taps of the seven-cell
// column-sum chain. Output row y appears while input row y+h streams in;
// after the frame send h*width drain requests (tuser = 1) to flush the last
// rows. Results are rounded to nearest (half up), saturated to 0..255.
// Write the registers only while the block is idle.
module symmetric_separable_convolution_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input pixels
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] pixel_in
    input  wire logic                         s_tuser,   // [0] func (1 = drain)
    // filtered pixels
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // end_of_row
    output logic                              m_tuser,   // [0] end_of_frame
    // register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    localparam int CW = ssc_pkg::CSUM_W;

    // ---------------- registers ----------------
    logic [ssc_pkg::CNT_W-1:0]  image_width_reg;
    logic [ssc_pkg::ROW_W-1:0]  image_height_reg;
    logic [ssc_pkg::HALF_W-1:0] half_width_reg;
    logic signed [ssc_pkg::COEF_W-1:0] coef_reg [0:ssc_pkg::MAX_HALF];
    ssc_pkg::ssc_reg_t reg_sel;
    logic cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = ssc_pkg::ssc_reg_t'(paddr[ssc_pkg::PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= ssc_pkg::CNT_W'(640);
            image_height_reg <= ssc_pkg::ROW_W'(480);
            half_width_reg   <= ssc_pkg::HALF_W'(1);
            coef_reg[0]      <= 16'sd16384;
            coef_reg[1]      <= '0;
            coef_reg[2]      <= '0;
            coef_reg[3]      <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                ssc_pkg::REG_WIDTH:  image_width_reg  <= pwdata[ssc_pkg::CNT_W-1:0];
                ssc_pkg::REG_HEIGHT: image_height_reg <= pwdata[ssc_pkg::ROW_W-1:0];
                ssc_pkg::REG_HALF:   half_width_reg   <= pwdata[ssc_pkg::HALF_W-1:0];
                ssc_pkg::REG_COEF0:  coef_reg[0]      <= pwdata[15:0];
                ssc_pkg::REG_COEF1:  coef_reg[1]      <= pwdata[15:0];
                ssc_pkg::REG_COEF2:  coef_reg[2]      <= pwdata[15:0];
                ssc_pkg::REG_COEF3:  coef_reg[3]      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ssc_pkg::REG_WIDTH:  prdata = 32'(image_width_reg);
            ssc_pkg::REG_HEIGHT: prdata = 32'(image_height_reg);
            ssc_pkg::REG_HALF:   prdata = 32'(half_width_reg);
            ssc_pkg::REG_COEF0:  prdata = 32'(unsigned'(coef_reg[0]));
            ssc_pkg::REG_COEF1:  prdata = 32'(unsigned'(coef_reg[1]));
            ssc_pkg::REG_COEF2:  prdata = 32'(unsigned'(coef_reg[2]));
            ssc_pkg::REG_COEF3:  prdata = 32'(unsigned'(coef_reg[3]));
            default:             prdata = '0;
        endcase
    end

    // effective geometry: zero acts as one, oversize clips
    logic [ssc_pkg::CNT_W-1:0] cols;
    logic [ssc_pkg::ROW_W-1:0] rows;
    logic [ssc_pkg::ROW_W:0]   ext_rows;   // rows + h
    always_comb begin
        cols = image_width_reg;
        if (image_width_reg == '0) cols = ssc_pkg::CNT_W'(1);
        else if (image_width_reg > ssc_pkg::CNT_W'(ssc_pkg::MAX_COLS))
            cols = ssc_pkg::CNT_W'(ssc_pkg::MAX_COLS);
        rows = image_height_reg;
        if (image_height_reg == '0) rows = ssc_pkg::ROW_W'(1);
        else if (image_height_reg > ssc_pkg::ROW_W'(ssc_pkg::MAX_ROWS))
            rows = ssc_pkg::ROW_W'(ssc_pkg::MAX_ROWS);
        ext_rows = {1'b0, rows} + (ssc_pkg::ROW_W+1)'(half_width_reg);
    end

    // ---------------- position ----------------
    logic [ssc_pkg::CNT_W-1:0]  col_cnt_reg;
    logic [ssc_pkg::ROW_W-1:0]  row_cnt_reg;
    logic [ssc_pkg::SLOT_W-1:0] slot_reg;     // row_cnt mod ring size

    // position of the request about to be taken (wraps after a config change)
    logic [ssc_pkg::COL_W-1:0]  in_c;
    logic [ssc_pkg::ROW_W-1:0]  in_r;
    logic [ssc_pkg::SLOT_W-1:0] in_slot;
    logic [ssc_pkg::ROW_W:0]    r_inc;
    always_comb begin
        in_c    = col_cnt_reg[ssc_pkg::COL_W-1:0];
        r_inc   = {1'b0, row_cnt_reg};
        in_slot = slot_reg;
        if (col_cnt_reg >= cols) begin
            in_c  = '0;
            r_inc = {1'b0, row_cnt_reg} + 1'b1;
            in_slot = (slot_reg == ssc_pkg::SLOT_W'(ssc_pkg::RING_ROWS-1)) ? '0
                                                                           : slot_reg + 1'b1;
        end
        if (r_inc >= ext_rows) begin
            r_inc   = '0;
            in_slot = '0;
        end
        in_r = r_inc[ssc_pkg::ROW_W-1:0];
    end

    // working copy for the request in flight
    logic [ssc_pkg::COL_W-1:0]  cur_c_reg;
    logic [ssc_pkg::ROW_W-1:0]  cur_r_reg;
    logic [ssc_pkg::SLOT_W-1:0] cur_slot_reg;
    logic [ssc_pkg::PIX_W-1:0]  p_reg;
    logic                       pixel_row_reg;

    // ---------------- state machine ----------------
    ssc_pkg::ssc_state_t state_reg, state_next;
    logic [ssc_pkg::TAP_W-1:0] tap_reg;
    logic [ssc_pkg::TAP_W-1:0] last_tap;
    logic s_acc, out_free, out_load, rd_en, wr_en, shift_en;
    logic in_has_col;
    logic signed [ssc_pkg::COL_W+1:0] lo, hi, x_reg;

    assign last_tap   = {half_width_reg, 1'b0};
    assign s_acc      = s_tvalid && s_tready;
    assign out_free   = !m_tvalid || m_tready;
    assign in_has_col = in_r >= ssc_pkg::ROW_W'(half_width_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ssc_pkg::ST_IDLE:
                if (s_tvalid) state_next = in_has_col ? ssc_pkg::ST_VADDR : ssc_pkg::ST_WRITE;
            ssc_pkg::ST_VADDR: state_next = ssc_pkg::ST_VMAC;
            ssc_pkg::ST_VMAC:
                state_next = (tap_reg == last_tap) ? ssc_pkg::ST_SHIFT : ssc_pkg::ST_VADDR;
            ssc_pkg::ST_SHIFT:
                state_next = (hi < lo) ? ssc_pkg::ST_WRITE : ssc_pkg::ST_HMAC;
            ssc_pkg::ST_HMAC:
                if (tap_reg == last_tap) state_next = ssc_pkg::ST_HOUT;
            ssc_pkg::ST_HOUT:
                if (out_free) state_next = (x_reg == hi) ? ssc_pkg::ST_WRITE : ssc_pkg::ST_HMAC;
            ssc_pkg::ST_WRITE: state_next = ssc_pkg::ST_IDLE;
            default: state_next = ssc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        shift_en = 1'b0;
        out_load = 1'b0;
        wr_en    = 1'b0;
        case (state_reg)
            ssc_pkg::ST_IDLE:  s_tready = aresetn;   // no request taken in reset
            ssc_pkg::ST_VADDR: rd_en    = 1'b1;
            ssc_pkg::ST_SHIFT: shift_en = 1'b1;
            ssc_pkg::ST_HOUT:  out_load = out_free;
            ssc_pkg::ST_WRITE: wr_en    = pixel_row_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- vertical pass ----------------
    // tap j covers row r - 2h + j, clamped into the frame
    logic signed [ssc_pkg::ROW_W+1:0] tap_row_s;
    logic [ssc_pkg::ROW_W-1:0]        tap_row;
    logic [ssc_pkg::ROW_W-1:0]        row_dist;
    logic [ssc_pkg::SLOT_W:0]         slot_sum;
    logic [ssc_pkg::SLOT_W-1:0]       tap_slot;
    logic [ssc_pkg::HALF_W-1:0]       tap_w;
    logic [ssc_pkg::PIX_W-1:0]        rd_data;
    logic                             use_p_reg;
    logic [ssc_pkg::HALF_W-1:0]       wsel_reg;
    logic signed [CW-1:0]             vacc_reg;
    logic [ssc_pkg::PIX_W-1:0]        vpix;

    always_comb begin
        tap_row_s = $signed({2'b00, cur_r_reg}) - $signed((ssc_pkg::ROW_W+2)'(last_tap))
                  + $signed((ssc_pkg::ROW_W+2)'(tap_reg));
        if (tap_row_s < 0) tap_row = '0;
        else if (tap_row_s > $signed({2'b00, rows - 1'b1})) tap_row = rows - 1'b1;
        else tap_row = tap_row_s[ssc_pkg::ROW_W-1:0];
        row_dist = cur_r_reg - tap_row;
        slot_sum = {1'b0, cur_slot_reg} + (ssc_pkg::SLOT_W+1)'(ssc_pkg::RING_ROWS)
                 - row_dist[ssc_pkg::SLOT_W:0];
        if (slot_sum >= (ssc_pkg::SLOT_W+1)'(ssc_pkg::RING_ROWS))
            slot_sum = slot_sum - (ssc_pkg::SLOT_W+1)'(ssc_pkg::RING_ROWS);
        tap_slot = (tap_row == '0) ? '0 : slot_sum[ssc_pkg::SLOT_W-1:0];
        tap_w    = (tap_reg >= ssc_pkg::TAP_W'(half_width_reg))
                 ? ssc_pkg::HALF_W'(tap_reg - ssc_pkg::TAP_W'(half_width_reg))
                 : ssc_pkg::HALF_W'(ssc_pkg::TAP_W'(half_width_reg) - tap_reg);
        vpix     = use_p_reg ? p_reg : rd_data;
    end

    ssc_line_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr ({cur_slot_reg, cur_c_reg}),
        .wr_data (p_reg),
        .rd_en   (rd_en),
        .rd_addr ({tap_slot, cur_c_reg}),
        .rd_data (rd_data)
    );

    // ---------------- column-sum chain ----------------
    logic signed [CW-1:0] cw [0:ssc_pkg::WIN_LEN];
    assign cw[0] = vacc_reg;

    for (genvar i = 0; i < ssc_pkg::WIN_LEN; i++) begin : g_cell
        ssc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d_in     (cw[i]),
            .q_out    (cw[i+1])
        );
    end

    // ---------------- horizontal pass ----------------
    logic signed [ssc_pkg::COL_W+1:0] c_s, h_s, pos;
    logic [ssc_pkg::TAP_W-1:0]        widx;
    logic signed [CW-1:0]             hsel;
    logic signed [ssc_pkg::HACC_W-1:0] hacc_reg, hround;
    logic [7:0]                       pix_sat;

    always_comb begin
        c_s = $signed({2'b00, cur_c_reg});
        h_s = $signed((ssc_pkg::COL_W+2)'(half_width_reg));
        lo  = (c_s >= h_s) ? c_s - h_s : '0;
        hi  = (({1'b0, cur_c_reg}) == cols - 1'b1) ? c_s : c_s - h_s;
        pos = x_reg + $signed((ssc_pkg::COL_W+2)'(tap_reg)) - h_s;
        if (pos < 0) pos = '0;
        else if (pos > c_s) pos = c_s;
        widx = ssc_pkg::TAP_W'(c_s - pos);   // window index, newest first
        hsel = cw[widx + 1'b1];
        hround = hacc_reg + (ssc_pkg::HACC_W'(1) <<< 27);
        if (hround < 0) pix_sat = '0;
        else if (hround[ssc_pkg::HACC_W-1:36] != '0) pix_sat = 8'hFF;
        else pix_sat = hround[35:28];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            slot_reg    <= '0;
            tap_reg     <= '0;
        end else begin
            case (state_reg)
                ssc_pkg::ST_IDLE:
                    if (s_acc) begin
                        cur_c_reg     <= in_c;
                        cur_r_reg     <= in_r;
                        cur_slot_reg  <= in_slot;
                        pixel_row_reg <= in_r < rows;
                        p_reg         <= (in_r < rows && !s_tuser) ? s_tdata : '0;
                        tap_reg       <= '0;
                        vacc_reg      <= '0;
                    end
                ssc_pkg::ST_VADDR: begin
                    use_p_reg <= tap_row == cur_r_reg;
                    wsel_reg  <= tap_w;
                end
                ssc_pkg::ST_VMAC: begin
                    vacc_reg <= vacc_reg + CW'(coef_reg[wsel_reg] * $signed({1'b0, vpix}));
                    tap_reg  <= tap_reg + 1'b1;
                end
                ssc_pkg::ST_SHIFT: begin
                    x_reg    <= lo;
                    tap_reg  <= '0;
                    hacc_reg <= '0;
                end
                ssc_pkg::ST_HMAC: begin
                    hacc_reg <= hacc_reg + ssc_pkg::HACC_W'(coef_reg[tap_w] * hsel);
                    tap_reg  <= tap_reg + 1'b1;
                end
                ssc_pkg::ST_HOUT:
                    if (out_free) begin
                        x_reg    <= x_reg + 1'b1;
                        tap_reg  <= '0;
                        hacc_reg <= '0;
                    end
                ssc_pkg::ST_WRITE:
                    if ({1'b0, cur_c_reg} + 1'b1 == cols) begin
                        col_cnt_reg <= '0;
                        if ({1'b0, cur_r_reg} + 1'b1 >= ext_rows) begin
                            row_cnt_reg <= '0;
                            slot_reg    <= '0;
                        end else begin
                            row_cnt_reg <= cur_r_reg + 1'b1;
                            slot_reg <= (cur_slot_reg == ssc_pkg::SLOT_W'(ssc_pkg::RING_ROWS-1))
                                      ? '0 : cur_slot_reg + 1'b1;
                        end
                    end else begin
                        col_cnt_reg <= {1'b0, cur_c_reg} + 1'b1;
                        row_cnt_reg <= cur_r_reg;
                        slot_reg    <= cur_slot_reg;
                    end
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg, m_tuser_reg;
    logic       eor;
    assign eor = x_reg == $signed({1'b0, cols - 1'b1});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= pix_sat;
            m_tlast_reg <= eor;
            m_tuser_reg <= eor && ({1'b0, cur_r_reg} == ext_rows - 1'b1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire
